### rtl/etcd_pkg.sv
// Shared types and constants of the exposure-to-clock-divider block.
// No dependencies; imported by etcd_divider, etcd_count and the top level.
package etcd_pkg;

  // Input and result field widths
  localparam int unsigned ExpW = 10;
  localparam int unsigned DivW = 6;
  localparam int unsigned CntW = 9;

  // Numerator of the line count: e * 45 * 448 fits in 25 bits
  localparam int unsigned NumW = 25;

  // Divider computation: ceil(90*e / 2000)
  localparam logic [16:0] DivNum   = 17'd90;
  localparam logic [16:0] DivRound = 17'd1999;
  localparam logic [10:0] DivDen   = 11'd2000;
  // floor(2^28 / 2000), underestimates the quotient by at most one
  localparam logic [17:0] DivRecip = 18'd134217;
  localparam int unsigned DivShift = 28;
  localparam logic [6:0]  DivMin   = 7'd6;
  localparam logic [6:0]  DivMax   = 7'd63;
  localparam logic [5:0]  DivFineMax = 6'd12;
  // floor(n * 43 / 128) == floor(n / 3) for every n below 128
  localparam logic [6:0]  Third    = 7'd43;
  localparam int unsigned ThirdShift = 7;

  // Line count: 448 - e*45*448 / (1000*d)
  localparam int unsigned LineMulInt  = 45;
  localparam int unsigned LineBaseInt = 448;
  localparam logic [NumW-1:0] LineMul  = NumW'(LineMulInt * LineBaseInt);
  localparam logic [12:0]     LineBase = 13'(LineBaseInt);
  localparam logic [9:0]      LineDen  = 10'd1000;
  localparam int unsigned     LineShift = 26;
  localparam int unsigned     RecipW    = 14;

  // Transaction between the divider and count sections
  typedef struct packed {
    logic [DivW-1:0] div;
    logic [NumW-1:0] num;
  } etcd_mid_t;

  // floor(2^26 / (1000*d)) for every divider the divider section can produce
  function automatic logic [RecipW-1:0] line_recip(input logic [DivW-1:0] d);
    logic [RecipW-1:0] r;
    case (d)
      6'd6:    r = 14'd11184;
      6'd7:    r = 14'd9586;
      6'd8:    r = 14'd8388;
      6'd9:    r = 14'd7456;
      6'd10:   r = 14'd6710;
      6'd11:   r = 14'd6100;
      6'd12:   r = 14'd5592;
      6'd15:   r = 14'd4473;
      6'd18:   r = 14'd3728;
      6'd21:   r = 14'd3195;
      6'd24:   r = 14'd2796;
      6'd27:   r = 14'd2485;
      6'd30:   r = 14'd2236;
      6'd33:   r = 14'd2033;
      6'd36:   r = 14'd1864;
      6'd39:   r = 14'd1720;
      6'd42:   r = 14'd1597;
      6'd45:   r = 14'd1491;
      6'd48:   r = 14'd1398;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/etcd_divider.sv
// Divider section: four pipeline stages from exposure value to clock divider.
// Depends on etcd_pkg.
module etcd_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [etcd_pkg::ExpW-1:0] exp_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output etcd_pkg::etcd_mid_t       out_o
);
  import etcd_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [16:0]     x1_q, x2_q;
  logic [NumW-1:0] n1_q, n2_q, n3_q, n4_q;
  logic [34:0]     p2_q;
  logic [6:0]      d3_q;
  logic [DivW-1:0] d4_q;

  logic [6:0]      q_est;
  logic [17:0]     q_prod;
  logic [16:0]     rem;
  logic [6:0]      d3_d;
  logic [DivW-1:0] d_clamp;
  logic [6:0]      n_up;
  logic [12:0]     t_third;
  logic [5:0]      q_third;
  logic [6:0]      m_three;
  logic [DivW-1:0] d4_d;

  // Stage can load when empty or when its contents move on
  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Correct the reciprocal quotient by one step
  always_comb begin
    q_est  = p2_q[34:DivShift];
    q_prod = 18'(q_est) * 18'(DivDen);
    rem    = x2_q - q_prod[16:0];
    d3_d   = q_est + 7'(rem >= 17'(DivDen));
  end

  // Clamp, then round a coarse divider up to a multiple of three
  always_comb begin
    if (d3_q < DivMin) begin
      d_clamp = DivMin[DivW-1:0];
    end else if (d3_q > DivMax) begin
      d_clamp = DivMax[DivW-1:0];
    end else begin
      d_clamp = d3_q[DivW-1:0];
    end
    n_up    = 7'(d_clamp) + 7'd2;
    t_third = 13'(n_up) * 13'(Third);
    q_third = t_third[12:ThirdShift];
    m_three = 7'(q_third) * 7'd3;
    d4_d    = (d_clamp > DivFineMax) ? m_three[DivW-1:0] : d_clamp;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      x1_q <= 17'(exp_i) * DivNum + DivRound;
      n1_q <= NumW'(exp_i) * LineMul;
    end
    if (rdy2 && v1_q) begin
      p2_q <= 35'(x1_q) * 35'(DivRecip);
      x2_q <= x1_q;
      n2_q <= n1_q;
    end
    if (rdy3 && v2_q) begin
      d3_q <= d3_d;
      n3_q <= n2_q;
    end
    if (rdy4 && v3_q) begin
      d4_q <= d4_d;
      n4_q <= n3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_o.div   = d4_q;
  assign out_o.num   = n4_q;

endmodule

### rtl/etcd_count.sv
// Count section: three pipeline stages from divider and numerator to line count.
// Depends on etcd_pkg.
module etcd_count (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  etcd_pkg::etcd_mid_t       in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [etcd_pkg::DivW-1:0] div_o,
  output logic [etcd_pkg::CntW-1:0] cnt_o
);
  import etcd_pkg::*;

  localparam int unsigned ProdW = NumW + RecipW;

  logic v5_q, v6_q, v7_q;
  logic rdy5, rdy6, rdy7;

  logic [ProdW-1:0] p5_q;
  logic [15:0]      den5_q, den6_q;
  logic [NumW-1:0]  n5_q, n6_q;
  logic [DivW-1:0]  d5_q, d6_q, d7_q;
  logic [12:0]      q6_q;
  logic [28:0]      qd6_q;
  logic [CntW-1:0]  c7_q;

  logic [12:0]     q_est;
  logic [NumW-1:0] rem;
  logic [12:0]     lines;
  logic [12:0]     cnt_full;

  assign rdy7 = !v7_q || out_ready_i;
  assign rdy6 = !v6_q || rdy7;
  assign rdy5 = !v5_q || rdy6;
  assign in_ready_o = rdy5;

  assign q_est = p5_q[ProdW-1:LineShift];

  // Correct the quotient, saturate and subtract from the base count
  always_comb begin
    rem   = n6_q - qd6_q[NumW-1:0];
    lines = q6_q + 13'(rem >= NumW'(den6_q));
    if (lines > LineBase) begin
      lines = LineBase;
    end
    cnt_full = LineBase - lines;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (rdy5) v5_q <= in_valid_i;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= v6_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (rdy5 && in_valid_i) begin
      p5_q   <= ProdW'(in_i.num) * ProdW'(line_recip(in_i.div));
      den5_q <= 16'(in_i.div) * 16'(LineDen);
      n5_q   <= in_i.num;
      d5_q   <= in_i.div;
    end
    if (rdy6 && v5_q) begin
      q6_q   <= q_est;
      qd6_q  <= 29'(q_est) * 29'(den5_q);
      den6_q <= den5_q;
      n6_q   <= n5_q;
      d6_q   <= d5_q;
    end
    if (rdy7 && v6_q) begin
      c7_q <= cnt_full[CntW-1:0];
      d7_q <= d6_q;
    end
  end

  assign out_valid_o = v7_q;
  assign div_o       = d7_q;
  assign cnt_o       = c7_q;

endmodule

### rtl/exposure_to_clock_divider.sv
// Exposure-to-clock-divider block: top level joining the two pipeline sections.
// Depends on etcd_pkg, etcd_divider and etcd_count.
//
// Usage:
//   Input channel: valid_i, stall_o, exposure_setting_i. A transaction is
//   taken at a rising edge with valid_i high and stall_o low.
//   Output channel: valid_o, stall_i, clock_divider_o, exposure_count_o. A
//   transaction completes at a rising edge with valid_o high and stall_i low.
//   Every input transaction yields exactly one output transaction, in order.
// Stages: seven register stages lie between input acceptance and valid_o
//   (four in the divider section, three in the count section: reciprocal
//   multiply, quotient times divisor, correction).
// Throughput: one transaction per cycle sustained while stall_i is low.
// Reset: rst_ni low clears all valid bits at once; no transaction is in
//   flight afterwards and valid_o is low.
// Stall: while stall_i holds a result, the output holds its value; each
//   stage keeps loading while the one ahead of it has room, so stall_o rises
//   only once every stage is occupied.
module exposure_to_clock_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [etcd_pkg::ExpW-1:0] exposure_setting_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [etcd_pkg::DivW-1:0] clock_divider_o,
  output logic [etcd_pkg::CntW-1:0] exposure_count_o
);
  import etcd_pkg::*;

  logic      div_ready;
  logic      mid_valid;
  logic      mid_ready;
  etcd_mid_t mid;

  // Compute the clock divider
  etcd_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_i),
    .in_ready_o  (div_ready),
    .exp_i       (exposure_setting_i),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_o       (mid)
  );

  // Compute the exposure line count
  etcd_count u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_i        (mid),
    .out_valid_o (valid_o),
    .out_ready_i (!stall_i),
    .div_o       (clock_divider_o),
    .cnt_o       (exposure_count_o)
  );

  assign stall_o = !div_ready;

endmodule

### rtl/etcd_checker.sv
// Port-level checks of the exposure-to-clock-divider block, bound to the top.
// Depends on etcd_pkg and exposure_to_clock_divider.
module etcd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      valid_i,
  input logic                      stall_o,
  input logic [etcd_pkg::ExpW-1:0] exposure_setting_i,
  input logic                      valid_o,
  input logic                      stall_i,
  input logic [etcd_pkg::DivW-1:0] clock_divider_o,
  input logic [etcd_pkg::CntW-1:0] exposure_count_o
);
  import etcd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(clock_divider_o)
      && $stable(exposure_count_o))
    else $error("stalled output transaction changed");

  // Divider stays in its reachable range
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> clock_divider_o >= 6'd6 && clock_divider_o <= 6'd48)
    else $error("clock divider out of range");

  // Count never wraps past the base
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> exposure_count_o <= CntW'(LineBaseInt))
    else $error("exposure count out of range");

  // Hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stall_o |=> valid_i && $stable(exposure_setting_i))
    else $error("stalled input transaction changed");

endmodule

bind exposure_to_clock_divider etcd_checker u_etcd_checker (.*);
